/* hw/rtl/cpio_pkg.sv */
// Shared types, constants and helper functions for the cpio newc stream parser.
// Used by cpio_parse_core and by the top level cpio_newc_stream_parser.
package cpio_pkg;

   localparam int ENTRY_INDEX_WIDTH = 16;
   localparam int HEADER_BYTES      = 110;
   localparam int MAGIC_BYTES       = 6;
   localparam int TRAILER_BYTES     = 10;
   localparam int FILESIZE_FIRST    = 54;
   localparam int FILESIZE_LAST     = 61;
   localparam int NAMESIZE_FIRST    = 94;
   localparam int NAMESIZE_LAST     = 101;

   // Section codes as they appear on the result port.
   localparam logic [2:0] SECT_CODE_HEADER  = 3'd0;
   localparam logic [2:0] SECT_CODE_NAME    = 3'd1;
   localparam logic [2:0] SECT_CODE_NAMEPAD = 3'd2;
   localparam logic [2:0] SECT_CODE_DATA    = 3'd3;
   localparam logic [2:0] SECT_CODE_DATAPAD = 3'd4;
   localparam logic [2:0] SECT_CODE_IGNORED = 3'd5;

   // Parser state, one-hot.
   typedef enum logic [5:0] {
      SEC_HEADER  = 6'b000001,
      SEC_NAME    = 6'b000010,
      SEC_NAMEPAD = 6'b000100,
      SEC_DATA    = 6'b001000,
      SEC_DATAPAD = 6'b010000,
      SEC_IGNORED = 6'b100000
   } sec_type;

   typedef enum logic [1:0] {
      STOP_RUN     = 2'd0,
      STOP_MAGIC   = 2'd1,
      STOP_TRAILER = 2'd2,
      STOP_TRUNC   = 2'd3
   } stop_type;

   typedef struct packed {
      logic [7:0]                   byte_out;
      logic [2:0]                   section;
      logic                         entry_start;
      logic [ENTRY_INDEX_WIDTH-1:0] entry_index;
      logic [31:0]                  name_length;
      logic [31:0]                  file_length;
      stop_type                     status;
   } rsp_fields_type;

   function automatic logic [2:0] sect_code(input sec_type s);
      logic [2:0] code;
      code = SECT_CODE_IGNORED;
      unique case (s)
         SEC_HEADER:  code = SECT_CODE_HEADER;
         SEC_NAME:    code = SECT_CODE_NAME;
         SEC_NAMEPAD: code = SECT_CODE_NAMEPAD;
         SEC_DATA:    code = SECT_CODE_DATA;
         SEC_DATAPAD: code = SECT_CODE_DATAPAD;
         default:     code = SECT_CODE_IGNORED;
      endcase
      return code;
   endfunction

   // Value of an ASCII hex digit; anything else counts as zero.
   function automatic logic [3:0] hex_digit(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= "0" && c <= "9") begin
         v = 4'(c - "0");
      end else if (c >= "a" && c <= "f") begin
         v = 4'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
         v = 4'(c - "A" + 8'd10);
      end
      return v;
   endfunction

   function automatic logic [7:0] magic_char(input logic [2:0] i);
      logic [7:0] c;
      c = "0";
      unique case (i)
         3'd0:    c = "0";
         3'd1:    c = "7";
         3'd2:    c = "0";
         3'd3:    c = "7";
         3'd4:    c = "0";
         3'd5:    c = "1";
         default: c = "0";
      endcase
      return c;
   endfunction

   function automatic logic [7:0] trailer_char(input logic [3:0] i);
      logic [7:0] c;
      c = "!";
      unique case (i)
         4'd0:    c = "T";
         4'd1:    c = "R";
         4'd2:    c = "A";
         4'd3:    c = "I";
         4'd4:    c = "L";
         4'd5:    c = "E";
         4'd6:    c = "R";
         default: c = "!";
      endcase
      return c;
   endfunction

endpackage

/* hw/rtl/cpio_parse_core.sv */
// Parser state and next-state logic: section tracking, size decoding, stops.
// Depends on cpio_pkg. Forms one result per stepped byte, combinationally.
module cpio_parse_core import cpio_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  logic [7:0]     arc_byte,
   input  logic           arc_last,
   output rsp_fields_type result
);

   sec_type                      sec_ff, sec_in;
   logic [31:0]                  count_ff, count_in;
   logic [1:0]                   offset_ff, offset_in;
   logic [31:0]                  hex_ff, hex_in;
   logic [31:0]                  name_size_ff, name_size_in;
   logic [31:0]                  file_size_ff, file_size_in;
   logic                         trailer_ff, trailer_in;
   logic [ENTRY_INDEX_WIDTH-1:0] entry_ff, entry_in;
   stop_type                     stop_ff, stop_in;

   logic [1:0]  off_new;
   logic [31:0] count_inc;
   logic [31:0] hex_base;
   logic        in_hex_field;
   logic        tm_new;
   logic        go_name, go_namepad, go_data, go_datapad, go_end;

   always_comb begin
      sec_in       = sec_ff;
      count_in     = count_ff;
      offset_in    = offset_ff;
      hex_in       = hex_ff;
      name_size_in = name_size_ff;
      file_size_in = file_size_ff;
      trailer_in   = trailer_ff;
      entry_in     = entry_ff;
      stop_in      = stop_ff;
      go_name      = 1'b0;
      go_namepad   = 1'b0;
      go_data      = 1'b0;
      go_datapad   = 1'b0;
      go_end       = 1'b0;
      off_new      = offset_ff + 2'd1;
      count_inc    = count_ff + 32'd1;
      in_hex_field = (count_ff >= 32'(FILESIZE_FIRST) && count_ff <= 32'(FILESIZE_LAST)) ||
                     (count_ff >= 32'(NAMESIZE_FIRST) && count_ff <= 32'(NAMESIZE_LAST));
      hex_base     = (count_ff == 32'(FILESIZE_FIRST) || count_ff == 32'(NAMESIZE_FIRST)) ?
                     32'd0 : hex_ff;
      tm_new       = trailer_ff &
                     !(count_ff < 32'(TRAILER_BYTES) && arc_byte != trailer_char(count_ff[3:0]));

      if (sec_ff != SEC_IGNORED) begin
         offset_in = off_new;
         unique case (sec_ff)
            SEC_HEADER: begin
               if (in_hex_field) begin
                  hex_in = {hex_base[27:0], hex_digit(arc_byte)};
                  if (count_ff == 32'(FILESIZE_LAST)) file_size_in = hex_in;
                  if (count_ff == 32'(NAMESIZE_LAST)) name_size_in = hex_in;
               end
               if (arc_last && count_ff < 32'(HEADER_BYTES - 1)) begin
                  stop_in = STOP_TRUNC;
               end else if (count_ff < 32'(MAGIC_BYTES) &&
                            arc_byte != magic_char(count_ff[2:0])) begin
                  stop_in = STOP_MAGIC;
               end
               if (stop_in == STOP_RUN) begin
                  if (count_ff == 32'(HEADER_BYTES - 1)) begin
                     trailer_in = 1'b1;
                     go_name    = 1'b1;
                  end else begin
                     count_in = count_inc;
                  end
               end
            end
            SEC_NAME: begin
               trailer_in = tm_new;
               if (tm_new && ((count_ff == 32'd9 && name_size_ff == 32'(TRAILER_BYTES)) ||
                              (count_ff == 32'(TRAILER_BYTES) && arc_byte == 8'd0))) begin
                  stop_in = STOP_TRAILER;
               end else if (count_inc == name_size_ff) begin
                  go_namepad = 1'b1;
               end else begin
                  count_in = count_inc;
               end
            end
            SEC_NAMEPAD: begin
               if (off_new == 2'd0) go_data = 1'b1;
            end
            SEC_DATA: begin
               if (count_inc == file_size_ff) go_datapad = 1'b1;
               else count_in = count_inc;
            end
            SEC_DATAPAD: begin
               if (off_new == 2'd0) go_end = 1'b1;
            end
            default: begin
            end
         endcase

         // Empty sections and aligned padding fall through without taking a byte.
         if (go_name) begin
            if (name_size_ff != 32'd0) begin
               sec_in   = SEC_NAME;
               count_in = 32'd0;
            end else begin
               go_namepad = 1'b1;
            end
         end
         if (go_namepad) begin
            if (off_new != 2'd0) sec_in = SEC_NAMEPAD;
            else go_data = 1'b1;
         end
         if (go_data) begin
            if (file_size_ff != 32'd0) begin
               sec_in   = SEC_DATA;
               count_in = 32'd0;
            end else begin
               go_datapad = 1'b1;
            end
         end
         if (go_datapad) begin
            if (off_new != 2'd0) sec_in = SEC_DATAPAD;
            else go_end = 1'b1;
         end
         if (go_end) begin
            sec_in   = SEC_HEADER;
            count_in = 32'd0;
            if (entry_ff != {ENTRY_INDEX_WIDTH{1'b1}}) entry_in = entry_ff + 1'b1;
         end
         if (stop_in != STOP_RUN) sec_in = SEC_IGNORED;
      end
   end

   always_comb begin
      result.byte_out    = arc_byte;
      result.section     = sect_code(sec_ff);
      result.entry_start = (sec_ff == SEC_HEADER) && (count_ff == 32'd0);
      result.entry_index = entry_ff;
      result.name_length = name_size_in;
      result.file_length = file_size_in;
      result.status      = stop_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && arc_last)) begin
         sec_ff       <= SEC_HEADER;
         count_ff     <= 32'd0;
         offset_ff    <= 2'd0;
         hex_ff       <= 32'd0;
         name_size_ff <= 32'd0;
         file_size_ff <= 32'd0;
         trailer_ff   <= 1'b1;
         entry_ff     <= '0;
         stop_ff      <= STOP_RUN;
      end else if (step_en) begin
         sec_ff       <= sec_in;
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         hex_ff       <= hex_in;
         name_size_ff <= name_size_in;
         file_size_ff <= file_size_in;
         trailer_ff   <= trailer_in;
         entry_ff     <= entry_in;
         stop_ff      <= stop_in;
      end
   end

   a_stop_ignores: assert property (@(posedge clock) disable iff (reset)
      (stop_ff != STOP_RUN) |-> (sec_ff == SEC_IGNORED))
      else $error("parse stopped but section is not ignored");

   a_header_bound: assert property (@(posedge clock) disable iff (reset)
      (sec_ff == SEC_HEADER) |-> (count_ff < 32'(HEADER_BYTES)))
      else $error("header position beyond header length");

   a_entry_monotonic: assert property (@(posedge clock) disable iff (reset)
      (step_en && !arc_last) |=> (entry_ff >= $past(entry_ff)))
      else $error("entry counter went backwards within an archive");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (step_en && arc_last) |=>
         (sec_ff == SEC_HEADER && count_ff == 32'd0 && stop_ff == STOP_RUN))
      else $error("final byte did not restart the parser");

endmodule

/* hw/rtl/cpio_newc_stream_parser.sv */
// cpio newc stream parser: each input transfer passes through the input register, then the result register.
// One byte is accepted per cycle; the input register and result register never stall a
// neighbor unless the result side holds off, and then both registers fill before stopping.
// Synchronous active-high reset returns the parser to the start of a new archive.
// Depends on cpio_pkg and cpio_parse_core.
module cpio_newc_stream_parser import cpio_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_archive_byte,
   input  logic                         req_last_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_byte_out,
   output logic [2:0]                   rsp_section,
   output logic                         rsp_entry_start,
   output logic [ENTRY_INDEX_WIDTH-1:0] rsp_entry_index,
   output logic [31:0]                  rsp_name_length,
   output logic [31:0]                  rsp_file_length,
   output logic [1:0]                   rsp_status
);

   // Input register: holds one accepted byte until the parser core steps on it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Result register: holds one finished result until the consumer takes it.
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_fields_type res_ff;
   rsp_fields_type core_result;

   logic out_free;
   logic advance;

   // The result register can take a new result when it is empty or being drained.
   // The core steps, and its state advances, exactly when a byte moves across.
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   cpio_parse_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .arc_byte (in_byte_ff),
      .arc_last (in_last_ff),
      .result   (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; they load only with a transfer.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_archive_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance) begin
         res_ff <= core_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_out    = res_ff.byte_out;
   assign rsp_section     = res_ff.section;
   assign rsp_entry_start = res_ff.entry_start;
   assign rsp_entry_index = res_ff.entry_index;
   assign rsp_name_length = res_ff.name_length;
   assign rsp_file_length = res_ff.file_length;
   assign rsp_status      = res_ff.status;

endmodule

/* sim/cpio_newc_stream_parser_test.sv */
// Self-checking testbench for cpio_newc_stream_parser: builds newc archives byte by byte,
// tags every byte with its own section tracker and compares each result transfer.
// Depends on cpio_pkg and on the parser RTL only.
module cpio_newc_stream_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cpio_pkg::*;

   localparam int ITEM_TARGET   = 1950;
   localparam int HOLD_CYCLES   = 80;
   localparam int STALL_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int REPORT_LINES  = 40;
   localparam int HEADER_FIELDS = 13;
   localparam int FILESIZE_FIELD = (FILESIZE_FIRST - MAGIC_BYTES) / 8;
   localparam int NAMESIZE_FIELD = (NAMESIZE_FIRST - MAGIC_BYTES) / 8;

   localparam logic [8*MAGIC_BYTES-1:0]   MAGIC_TEXT   = "070701";
   localparam logic [8*TRAILER_BYTES-1:0] TRAILER_TEXT = "TRAILER!!!";
   // Characters just outside the hex ranges, plus the two byte extremes.
   localparam logic [63:0] NOT_HEX = {"/:@G", 8'h60, "g", 8'h00, 8'hFF};

   typedef enum {NAME_PLAIN, NAME_TRAILER, NAME_ALTERED} name_kind_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } feed_item_type;

   typedef struct packed {
      logic [7:0]                   data;
      logic [2:0]                   section;
      logic                         first;
      logic [ENTRY_INDEX_WIDTH-1:0] entry;
      logic [31:0]                  name_len;
      logic [31:0]                  file_len;
      logic [1:0]                   status;
   } parse_tag_type;

   // Block ports. Every input has a known value from time zero.
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_archive_byte = 8'd0;
   logic                         req_last_byte = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [7:0]                   rsp_byte_out;
   logic [2:0]                   rsp_section;
   logic                         rsp_entry_start;
   logic [ENTRY_INDEX_WIDTH-1:0] rsp_entry_index;
   logic [31:0]                  rsp_name_length;
   logic [31:0]                  rsp_file_length;
   logic [1:0]                   rsp_status;

   cpio_newc_stream_parser dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stimulus and scoreboard storage.
   logic [7:0]    archive_bytes[$];
   feed_item_type byte_feed[$];
   parse_tag_type expected_tags[$];

   int total_items;
   int offered_count;
   int results_seen;
   int archives_built;
   int entries_seen;
   int mismatch_count;
   int hold_left;
   int stalled_cycles;
   int stop_tally[4];
   bit drain_done;
   feed_item_type next_item;

   // Section tracker state. It mirrors what the parser must hold between bytes.
   logic [2:0]                   trk_section;
   logic [31:0]                  trk_pos;
   logic [1:0]                   trk_align;
   logic [31:0]                  trk_hex;
   logic [31:0]                  trk_name_size;
   logic [31:0]                  trk_file_size;
   logic                         trk_trailer_ok;
   logic [ENTRY_INDEX_WIDTH-1:0] trk_entry;
   stop_type                     trk_stop;

   function automatic void restart_archive();
      trk_section    = SECT_CODE_HEADER;
      trk_pos        = 32'd0;
      trk_align      = 2'd0;
      trk_hex        = 32'd0;
      trk_name_size  = 32'd0;
      trk_file_size  = 32'd0;
      trk_trailer_ok = 1'b1;
      trk_entry      = '0;
      trk_stop       = STOP_RUN;
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - 8'h30);
      if (c >= "a" && c <= "f") return 4'(c - 8'h57);
      if (c >= "A" && c <= "F") return 4'(c - 8'h37);
      return 4'd0;
   endfunction

   // Moves into a section and falls through every section that would be empty:
   // a zero-size name or file, or padding at an offset that is already aligned.
   // Falling out of the data padding closes the entry.
   function automatic void enter_section(input logic [2:0] target);
      logic [2:0] s;
      bit         done;
      s = target;
      done = 1'b0;
      trk_pos = 32'd0;
      while (!done) begin
         case (s)
            SECT_CODE_NAME: begin
               if (trk_name_size == 0) s = SECT_CODE_NAMEPAD;
               else done = 1'b1;
            end
            SECT_CODE_NAMEPAD: begin
               if (trk_align == 0) s = SECT_CODE_DATA;
               else done = 1'b1;
            end
            SECT_CODE_DATA: begin
               if (trk_file_size == 0) s = SECT_CODE_DATAPAD;
               else done = 1'b1;
            end
            SECT_CODE_DATAPAD: begin
               if (trk_align == 0) begin
                  s = SECT_CODE_HEADER;
                  if (trk_entry != '1) trk_entry = trk_entry + 1'b1;
               end else begin
                  done = 1'b1;
               end
            end
            default: done = 1'b1;
         endcase
      end
      trk_section = s;
   endfunction

   // Works out the tag of one accepted byte and advances the tracker.
   function automatic parse_tag_type tag_byte(input logic [7:0] b, input logic last);
      parse_tag_type tag;
      logic [31:0]   pos;
      logic [31:0]   base;
      tag.data    = b;
      tag.section = (trk_stop != STOP_RUN) ? SECT_CODE_IGNORED : trk_section;
      tag.first   = (tag.section == SECT_CODE_HEADER) && (trk_pos == 0);
      tag.entry   = trk_entry;
      pos = trk_pos;
      if (tag.section != SECT_CODE_IGNORED) begin
         trk_align = trk_align + 2'd1;
         case (tag.section)
            SECT_CODE_HEADER: begin
               // Size fields shift by a nibble per character; a non-hex one adds zero.
               if ((pos >= FILESIZE_FIRST && pos <= FILESIZE_LAST) ||
                   (pos >= NAMESIZE_FIRST && pos <= NAMESIZE_LAST)) begin
                  base = (pos == FILESIZE_FIRST || pos == NAMESIZE_FIRST) ? 32'd0 : trk_hex;
                  trk_hex = (base << 4) + nibble_of(b);
                  if (pos == FILESIZE_LAST) trk_file_size = trk_hex;
                  if (pos == NAMESIZE_LAST) trk_name_size = trk_hex;
               end
               // An archive that ends inside the header wins over a bad magic.
               if (last && pos < HEADER_BYTES - 1) begin
                  trk_stop = STOP_TRUNC;
               end else if (pos < MAGIC_BYTES &&
                            b != MAGIC_TEXT[8*(MAGIC_BYTES-1-pos) +: 8]) begin
                  trk_stop = STOP_MAGIC;
               end
               if (trk_stop == STOP_RUN) begin
                  if (pos == HEADER_BYTES - 1) begin
                     trk_trailer_ok = 1'b1;
                     enter_section(SECT_CODE_NAME);
                  end else begin
                     trk_pos = pos + 1;
                  end
               end
            end
            SECT_CODE_NAME: begin
               if (pos < TRAILER_BYTES && b != TRAILER_TEXT[8*(TRAILER_BYTES-1-pos) +: 8]) begin
                  trk_trailer_ok = 1'b0;
               end
               // The trailer is decided on its last character when the size is exact,
               // or on the terminating zero when the name is longer.
               if (trk_trailer_ok &&
                   ((pos == TRAILER_BYTES - 1 && trk_name_size == TRAILER_BYTES) ||
                    (pos == TRAILER_BYTES && b == 8'd0))) begin
                  trk_stop = STOP_TRAILER;
               end else if (pos + 1 == trk_name_size) begin
                  enter_section(SECT_CODE_NAMEPAD);
               end else begin
                  trk_pos = pos + 1;
               end
            end
            SECT_CODE_NAMEPAD: begin
               if (trk_align == 0) enter_section(SECT_CODE_DATA);
            end
            SECT_CODE_DATA: begin
               if (pos + 1 == trk_file_size) enter_section(SECT_CODE_DATAPAD);
               else trk_pos = pos + 1;
            end
            default: begin
               if (trk_align == 0) enter_section(SECT_CODE_DATAPAD);
            end
         endcase
         if (trk_stop != STOP_RUN) begin
            trk_section = SECT_CODE_IGNORED;
            stop_tally[trk_stop]++;
         end
      end
      tag.name_len = trk_name_size;
      tag.file_len = trk_file_size;
      tag.status   = trk_stop;
      if (tag.first) entries_seen++;
      // The final byte of an archive leaves the parser ready for a new one.
      if (last) restart_archive();
      return tag;
   endfunction

   // Archive construction helpers.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 10) return 8'h30 + 8'(n);
      c = ($urandom_range(1) == 1) ? "A" : "a";
      return c + 8'(n) - 8'd10;
   endfunction

   // Writes an 8-character size field. Zero nibbles sometimes become a non-hex
   // character, which leaves the decoded value unchanged.
   task automatic append_size_field(input logic [31:0] value);
      logic [3:0] nib;
      for (int i = 7; i >= 0; i--) begin
         nib = value[4*i +: 4];
         if (nib == 0 && $urandom_range(3) == 0) begin
            archive_bytes.push_back(NOT_HEX[8*$urandom_range(7) +: 8]);
         end else begin
            archive_bytes.push_back(hex_char(nib));
         end
      end
   endtask

   task automatic append_header(input logic [31:0] name_size, input logic [31:0] file_size);
      for (int i = 0; i < MAGIC_BYTES; i++) begin
         archive_bytes.push_back(MAGIC_TEXT[8*(MAGIC_BYTES-1-i) +: 8]);
      end
      for (int k = 0; k < HEADER_FIELDS; k++) begin
         if (k == FILESIZE_FIELD) begin
            append_size_field(file_size);
         end else if (k == NAMESIZE_FIELD) begin
            append_size_field(name_size);
         end else if ($urandom_range(3) == 0) begin
            repeat (8) archive_bytes.push_back(8'($urandom_range(255)));
         end else begin
            append_size_field($urandom());
         end
      end
   endtask

   task automatic append_data(input int len);
      repeat (len) archive_bytes.push_back(8'($urandom_range(255)));
   endtask

   task automatic append_align();
      while (archive_bytes.size() % 4 != 0) archive_bytes.push_back(8'd0);
   endtask

   // A trailer-like name carries the trailer text, a zero, then filler. An altered
   // one has exactly one of its first eleven characters changed.
   task automatic append_name(input int len, input name_kind_type kind);
      int         altered;
      logic [7:0] c;
      altered = -1;
      if (kind == NAME_ALTERED) begin
         altered = $urandom_range(((len < TRAILER_BYTES + 1) ? len : TRAILER_BYTES + 1) - 1);
      end
      for (int i = 0; i < len; i++) begin
         if (kind == NAME_PLAIN) begin
            c = (i == len - 1) ? 8'd0 : 8'($urandom_range(255));
         end else if (i < TRAILER_BYTES) begin
            c = TRAILER_TEXT[8*(TRAILER_BYTES-1-i) +: 8];
         end else if (i == TRAILER_BYTES) begin
            c = 8'd0;
         end else begin
            c = 8'($urandom_range(255));
         end
         if (i == altered) c = c ^ 8'($urandom_range(255, 1));
         archive_bytes.push_back(c);
      end
   endtask

   task automatic add_entry(input int name_len, input int file_len, input name_kind_type kind);
      append_header(name_len, file_len);
      append_name(name_len, kind);
      append_align();
      append_data(file_len);
      append_align();
   endtask

   // Hands the archive to the driver, optionally cut short; its final byte
   // carries the end-of-archive flag.
   task automatic flush_archive(input int cut);
      feed_item_type item;
      if (cut > 0 && cut < archive_bytes.size()) archive_bytes = archive_bytes[0:cut-1];
      foreach (archive_bytes[i]) begin
         item.value = archive_bytes[i];
         item.last  = (i == archive_bytes.size() - 1);
         byte_feed.push_back(item);
      end
      archive_bytes.delete();
      archives_built++;
   endtask

   function automatic int pick_name_len();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 0;
      if (r < 12) return $urandom_range(300, 256);
      return $urandom_range(24, 1);
   endfunction

   function automatic int pick_file_len();
      int r;
      r = $urandom_range(99);
      if (r < 12) return 0;
      if (r < 15) return $urandom_range(200, 100);
      return $urandom_range(48, 1);
   endfunction

   // Idle rates per side: sender light and receiver heavy first, then the
   // reverse, then a final stretch where neither side idles.
   function automatic int idle_percent(input bit sender_side);
      if (offered_count < total_items / 3) return sender_side ? 26 : 52;
      if (offered_count < 2 * total_items / 3) return sender_side ? 52 : 26;
      return 0;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
         $display("mismatch on result %0d: %s got %0h, expected %0h",
                  results_seen, what, got, want);
      end
   endtask

   task automatic check_result();
      parse_tag_type want;
      if (expected_tags.size() == 0) begin
         report_mismatch("transfer with nothing expected, byte_out", 32'(rsp_byte_out),
                         32'd0);
         return;
      end
      want = expected_tags.pop_front();
      if (rsp_byte_out !== want.data) begin
         report_mismatch("byte_out", 32'(rsp_byte_out), 32'(want.data));
      end
      if (rsp_section !== want.section) begin
         report_mismatch("section", 32'(rsp_section), 32'(want.section));
      end
      if (rsp_entry_start !== want.first) begin
         report_mismatch("entry_start", 32'(rsp_entry_start), 32'(want.first));
      end
      if (rsp_entry_index !== want.entry) begin
         report_mismatch("entry_index", 32'(rsp_entry_index), 32'(want.entry));
      end
      if (rsp_name_length !== want.name_len) begin
         report_mismatch("name_length", rsp_name_length, want.name_len);
      end
      if (rsp_file_length !== want.file_len) begin
         report_mismatch("file_length", rsp_file_length, want.file_len);
      end
      if (rsp_status !== want.status) begin
         report_mismatch("status", 32'(rsp_status), 32'(want.status));
      end
   endtask

   // Driver. A byte is predicted at the edge where its transfer completes. The
   // next byte is put up only when nothing is waiting on the port, so valid and
   // payload stay put until the transfer. Once, halfway through, the sender stops
   // until every expected result has come back. While the receiver holds off
   // the sender keeps offering, which fills the parser and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_tags.push_back(tag_byte(req_archive_byte, req_last_byte));
         end
         if (!req_valid || req_ready) begin
            if (!drain_done && offered_count == total_items / 2 && expected_tags.size() == 0) begin
               drain_done = 1'b1;
            end
            if (byte_feed.size() == 0 ||
                (!drain_done && offered_count == total_items / 2) ||
                (hold_left == 0 && $urandom_range(99) < idle_percent(1'b1))) begin
               req_valid <= 1'b0;
            end else begin
               next_item = byte_feed.pop_front();
               req_valid        <= 1'b1;
               req_archive_byte <= next_item.value;
               req_last_byte    <= next_item.last;
               offered_count++;
            end
         end
      end
   end

   // Monitor and receiver. Results are checked at the edge of their transfer.
   // Twice in the run the receiver holds off for a long stretch that it counts
   // itself.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result();
            results_seen++;
            if (results_seen == total_items / 6 || results_seen == 5 * total_items / 6) begin
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_percent(1'b0));
         end
      end
   end

   // Watchdog: a long run of cycles without any transfer means the block hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles == STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("cpio_newc_stream_parser_test NOT OK");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      int pick;
      int ending;
      restart_archive();

      // Directed archives.
      // A lone byte that ends the archive is a truncated header, even when it
      // also breaks the magic.
      archive_bytes.push_back("0");
      flush_archive(0);
      archive_bytes.push_back("X");
      flush_archive(0);
      // Magic broken on its third character; the bytes behind it are ignored.
      append_header(4, 4);
      archive_bytes[2] = "X";
      flush_archive(12);
      // A header whose last byte ends the archive is complete, not truncated.
      append_header(4, 4);
      flush_archive(HEADER_BYTES);
      // Empty name and empty file, a name that only looks like the trailer, then
      // the trailer with its exact size and some ignored bytes behind it.
      add_entry(0, 0, NAME_PLAIN);
      add_entry(10, 3, NAME_ALTERED);
      add_entry(10, 0, NAME_TRAILER);
      append_data(3);
      flush_archive(0);
      // Trailer told by the zero that follows it inside a longer name.
      add_entry(13, 0, NAME_TRAILER);
      flush_archive(0);
      // Largest size values: the archive ends inside the name, then inside data.
      append_header(32'hFFFF_FFFF, 32'd0);
      append_data(6);
      flush_archive(0);
      append_header(32'd1, 32'hFFFF_FFFF);
      append_data(12);
      flush_archive(0);

      // Random archives, mostly well formed with random content.
      while (byte_feed.size() < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            repeat ($urandom_range(3, 1)) add_entry(pick_name_len(), pick_file_len(), NAME_PLAIN);
            ending = $urandom_range(3);
            if (ending < 2) begin
               add_entry(($urandom_range(1) == 1) ? TRAILER_BYTES : $urandom_range(16, 11),
                         pick_file_len(), NAME_TRAILER);
               append_data($urandom_range(6));
               flush_archive(0);
            end else if (ending == 2) begin
               flush_archive(0);
            end else begin
               flush_archive($urandom_range(archive_bytes.size() - 1, 1));
            end
         end else if (pick < 72) begin
            append_header($urandom_range(20), $urandom_range(20));
            pick = $urandom_range(MAGIC_BYTES - 1);
            archive_bytes[pick] = archive_bytes[pick] ^ 8'($urandom_range(255, 1));
            append_data($urandom_range(8, 1));
            flush_archive(0);
         end else if (pick < 80) begin
            add_entry($urandom_range(16, 5), pick_file_len(), NAME_ALTERED);
            flush_archive(0);
         end else if (pick < 90) begin
            append_header($urandom_range(20), $urandom_range(20));
            flush_archive($urandom_range(HEADER_BYTES - 1, 1));
         end else begin
            append_data($urandom_range(40, 1));
            flush_archive(0);
         end
      end
      total_items = byte_feed.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Let everything drain, then give stray results time to show up.
      while (byte_feed.size() != 0 || req_valid || expected_tags.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_tags.size() != 0) begin
         report_mismatch("results never delivered", expected_tags.size(), 32'd0);
      end

      $display("Run covered %0d bytes in %0d archives with %0d entry headers.",
               results_seen, archives_built, entries_seen);
      $display("Stops: %0d bad magic, %0d trailer, %0d truncated header; %0d mismatches.",
               stop_tally[STOP_MAGIC], stop_tally[STOP_TRAILER], stop_tally[STOP_TRUNC],
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("cpio_newc_stream_parser_test OK");
      end else begin
         $display("cpio_newc_stream_parser_test NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/cpio_pkg.sv
hw/rtl/cpio_parse_core.sv
hw/rtl/cpio_newc_stream_parser.sv
sim/cpio_newc_stream_parser_test.sv
